// File: rtl/core/ptc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM throttle conditioner package
// Shared widths, constants, codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package ptc_pkg;

    localparam int DUTY_W     = 10;
    localparam int PERIOD_W   = 16;
    localparam int QUO_W      = 10;
    localparam int PROD_W     = PERIOD_W + QUO_W;
    localparam int DIV_CNT_W  = 4;
    localparam int LOSS_W     = 16;
    localparam int INTERVAL_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int                    DUTY_LIMIT = 1000;
    localparam logic [DUTY_W-1:0]     DUTY_MAX   = 10'd1000;
    localparam logic [DIV_CNT_W-1:0]  DIV_STEPS  = 4'd10;

    localparam logic [DUTY_W-1:0]     DEAD_ZONE_RST    = 10'd50;
    localparam logic [LOSS_W-1:0]     LOSS_TIMEOUT_RST = 16'd500;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RST     = 8'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOSS_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL     = 2'd2;

    typedef enum logic [1:0] {
        KIND_CAPTURE = 2'd0,
        KIND_TICK    = 2'd1,
        KIND_POLL    = 2'd2,
        KIND_CLEAR   = 2'd3
    } kind_t;

    typedef struct packed {
        logic load;
        logic loss_reload;
        logic duty_zero;
        logic duty_full;
        logic div_load_duty;
        logic div_step;
        logic duty_commit;
        logic avg_commit;
        logic tick;
        logic poll_update;
        logic ring_write;
        logic ring_clear;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  period_zero;
        logic  high_ge_period;
        logic  interval_zero;
        logic  div_done;
        logic  out_busy;
    } sts_t;

endpackage

// File: rtl/core/ptc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ptc_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/core/ptc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM throttle conditioner controller
// Sequences capture, tick, poll and clear transactions over the datapath.
// ----------------------------------------------------------------------------
module ptc_ctrl
    import ptc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output cmd_t cmd,
    input  sts_t sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DUTY_DIV,
        S_RING_WR,
        S_AVG,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (sts.kind)
                    KIND_CAPTURE: begin
                        cmd.loss_reload = 1'b1;
                        if (sts.period_zero) begin
                            cmd.duty_zero = 1'b1;
                            state_next    = S_EMIT;
                        end else if (sts.high_ge_period) begin
                            cmd.duty_full = 1'b1;
                            state_next    = S_EMIT;
                        end else begin
                            cmd.div_load_duty = 1'b1;
                            state_next        = S_DUTY_DIV;
                        end
                    end
                    KIND_TICK: begin
                        cmd.tick   = 1'b1;
                        state_next = S_EMIT;
                    end
                    KIND_POLL: begin
                        if (sts.interval_zero) begin
                            cmd.poll_update = 1'b1;
                            state_next      = S_RING_WR;
                        end else begin
                            state_next = S_EMIT;
                        end
                    end
                    default: begin
                        cmd.ring_clear = 1'b1;
                        state_next     = S_EMIT;
                    end
                endcase
            end
            S_DUTY_DIV: begin
                if (sts.div_done) begin
                    cmd.duty_commit = 1'b1;
                    state_next      = S_EMIT;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            S_RING_WR: begin
                cmd.ring_write = 1'b1;
                state_next     = S_AVG;
            end
            S_AVG: begin
                cmd.avg_commit = 1'b1;
                state_next     = S_EMIT;
            end
            S_EMIT: begin
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    ap_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a transaction is in progress");

    ap_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !sts.out_busy)
        else $error("output register overwritten while occupied");

    ap_idle_div: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> sts.div_done)
        else $error("divider still running while idle");

endmodule

// File: rtl/core/ptc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM throttle conditioner datapath
// Configuration, timers, serial divider, sample ring and output register.
// ----------------------------------------------------------------------------
module ptc_datapath
    import ptc_pkg::*;
#(
    parameter int AVG_TAPS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    input  logic [1:0]            s_kind,
    input  logic [PERIOD_W-1:0]   s_pwm_period,
    input  logic [PERIOD_W-1:0]   s_pwm_high_time,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DUTY_W-1:0]     m_throttle_level,
    output logic [DUTY_W-1:0]     m_filtered_duty,
    output logic                  m_signal_present,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PTR_W = $clog2(AVG_TAPS);
    localparam int SUM_W = $clog2(AVG_TAPS * DUTY_LIMIT + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(AVG_TAPS - 1);
    localparam logic [SUM_W-1:0] SUM_MAX  = SUM_W'(AVG_TAPS * DUTY_LIMIT);

    localparam int RECIP_SHIFT = SUM_W + PTR_W;
    localparam int RECIP_W     = SUM_W + 1;
    localparam int AVG_PROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << RECIP_SHIFT) + AVG_TAPS - 1) / AVG_TAPS);

    kind_t                 kind_reg;
    logic [PERIOD_W-1:0]   period_reg;
    logic [PERIOD_W-1:0]   high_reg;

    logic [DUTY_W-1:0]     dead_zone_reg;
    logic [LOSS_W-1:0]     loss_timeout_reg;
    logic [INTERVAL_W-1:0] interval_ticks_reg;

    logic [DUTY_W-1:0]     latest_duty_reg;
    logic [LOSS_W-1:0]     loss_cnt_reg;
    logic [INTERVAL_W-1:0] interval_cnt_reg;
    logic [DUTY_W-1:0]     avg_reg;
    logic [AVG_PROD_W-1:0] avg_prod;

    logic [PTR_W-1:0]      ring_ptr_reg;
    logic [SUM_W-1:0]      ring_sum_reg;
    logic [AVG_TAPS-1:0]   ring_valid_reg;
    logic [DUTY_W-1:0]     sample_reg;
    logic                  old_valid_reg;
    logic [DUTY_W-1:0]     ram_rdata;
    logic [DUTY_W-1:0]     old_sample;
    logic [SUM_W-1:0]      sum_next;

    logic [PERIOD_W-1:0]   div_rem_reg;
    logic [QUO_W-1:0]      div_num_reg;
    logic [PERIOD_W-1:0]   div_dvs_reg;
    logic [DIV_CNT_W-1:0]  div_cnt_reg;
    logic [PROD_W-1:0]     product;
    logic [PERIOD_W:0]     trial;
    logic [PERIOD_W:0]     trial_diff;
    logic                  trial_ge;

    logic                  m_valid_reg;
    logic [DUTY_W-1:0]     level_reg;
    logic [DUTY_W-1:0]     filt_reg;
    logic                  present_reg;
    logic [DUTY_W-1:0]     level;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dead_zone_reg      <= DEAD_ZONE_RST;
            loss_timeout_reg   <= LOSS_TIMEOUT_RST;
            interval_ticks_reg <= INTERVAL_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_DEAD_ZONE:    dead_zone_reg      <= cfg_data[DUTY_W-1:0];
                CFG_LOSS_TIMEOUT: loss_timeout_reg   <= cfg_data[LOSS_W-1:0];
                CFG_INTERVAL:     interval_ticks_reg <= cfg_data[INTERVAL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg   <= kind_t'(s_kind);
            period_reg <= s_pwm_period;
            high_reg   <= s_pwm_high_time;
        end
    end

    assign avg_prod = AVG_PROD_W'(ring_sum_reg) * AVG_PROD_W'(RECIP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latest_duty_reg  <= '0;
            loss_cnt_reg     <= '0;
            interval_cnt_reg <= '0;
            avg_reg          <= '0;
        end else begin
            if (cmd.duty_zero) begin
                latest_duty_reg <= '0;
            end else if (cmd.duty_full) begin
                latest_duty_reg <= DUTY_MAX;
            end else if (cmd.duty_commit) begin
                latest_duty_reg <= div_num_reg;
            end
            if (cmd.loss_reload) begin
                loss_cnt_reg <= loss_timeout_reg;
            end else if (cmd.tick && loss_cnt_reg != '0) begin
                loss_cnt_reg <= loss_cnt_reg - 1'b1;
            end
            if (cmd.poll_update) begin
                interval_cnt_reg <= interval_ticks_reg;
            end else if (cmd.tick && interval_cnt_reg != '0) begin
                interval_cnt_reg <= interval_cnt_reg - 1'b1;
            end
            if (cmd.avg_commit) begin
                avg_reg <= avg_prod[RECIP_SHIFT +: DUTY_W];
            end
        end
    end

    ptc_ram #(
        .WIDTH (DUTY_W),
        .DEPTH (AVG_TAPS)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (cmd.ring_write),
        .wr_addr (ring_ptr_reg),
        .wr_data (sample_reg),
        .rd_en   (cmd.poll_update),
        .rd_addr (ring_ptr_reg),
        .rd_data (ram_rdata)
    );

    assign old_sample = old_valid_reg ? ram_rdata : '0;
    assign sum_next   = ring_sum_reg - SUM_W'(old_sample) + SUM_W'(sample_reg);

    always_ff @(posedge aclk) begin
        if (cmd.poll_update) begin
            sample_reg    <= (loss_cnt_reg != '0) ? latest_duty_reg : '0;
            old_valid_reg <= ring_valid_reg[ring_ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_ptr_reg   <= '0;
            ring_sum_reg   <= '0;
            ring_valid_reg <= '0;
        end else if (cmd.ring_clear) begin
            ring_ptr_reg   <= '0;
            ring_sum_reg   <= '0;
            ring_valid_reg <= '0;
        end else if (cmd.ring_write) begin
            ring_valid_reg[ring_ptr_reg] <= 1'b1;
            ring_sum_reg                 <= sum_next;
            ring_ptr_reg <= (ring_ptr_reg == PTR_LAST) ? '0 : ring_ptr_reg + 1'b1;
        end
    end

    assign product    = PROD_W'(high_reg) * PROD_W'(DUTY_LIMIT);
    assign trial      = {div_rem_reg, div_num_reg[QUO_W-1]};
    assign trial_ge   = (trial >= {1'b0, div_dvs_reg});
    assign trial_diff = trial - {1'b0, div_dvs_reg};

    always_ff @(posedge aclk) begin
        if (cmd.div_load_duty) begin
            div_rem_reg <= product[PROD_W-1:QUO_W];
            div_num_reg <= product[QUO_W-1:0];
            div_dvs_reg <= period_reg;
        end else if (cmd.div_step) begin
            div_rem_reg <= trial_ge ? trial_diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
            div_num_reg <= {div_num_reg[QUO_W-2:0], trial_ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else if (cmd.div_load_duty) begin
            div_cnt_reg <= DIV_STEPS;
        end else if (cmd.div_step) begin
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end
    end

    assign level = (avg_reg < dead_zone_reg) ? '0 : avg_reg - dead_zone_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            level_reg   <= level;
            filt_reg    <= avg_reg;
            present_reg <= (loss_cnt_reg != '0);
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_throttle_level = level_reg;
    assign m_filtered_duty  = filt_reg;
    assign m_signal_present = present_reg;

    always_comb begin
        sts.kind           = kind_reg;
        sts.period_zero    = (period_reg == '0);
        sts.high_ge_period = (high_reg >= period_reg);
        sts.interval_zero  = (interval_cnt_reg == '0);
        sts.div_done       = (div_cnt_reg == '0);
        sts.out_busy       = m_valid_reg && !m_ready;
    end

    ap_duty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        latest_duty_reg <= DUTY_MAX && avg_reg <= DUTY_MAX)
        else $error("duty or average above full scale");

    ap_sum_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ring_sum_reg <= SUM_MAX)
        else $error("ring sum above full scale");

    ap_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        div_cnt_reg != '0 |-> div_rem_reg < div_dvs_reg)
        else $error("divider remainder not below divisor");

endmodule

// File: rtl/core/pwm_throttle_conditioner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM throttle conditioner
// Duty measurement, signal-loss timeout and moving-average throttle filter.
// ----------------------------------------------------------------------------
// Tick, clear, idle polls and captures needing no division go from decode to
// the output register; a filter update first writes the ring and commits the
// average, and a dividing capture first runs the 10-step serial duty divider.
// One transaction at a time; the next is accepted the cycle after the result
// enters the output register, which waits while the output is stalled.
// Reset clears the ring, timers, duty, average and the output valid flag.
// ----------------------------------------------------------------------------
module pwm_throttle_conditioner
    import ptc_pkg::*;
#(
    parameter int AVG_TAPS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_kind,
    input  logic [PERIOD_W-1:0]   s_pwm_period,
    input  logic [PERIOD_W-1:0]   s_pwm_high_time,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DUTY_W-1:0]     m_throttle_level,
    output logic [DUTY_W-1:0]     m_filtered_duty,
    output logic                  m_signal_present,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    ptc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    ptc_datapath #(
        .AVG_TAPS (AVG_TAPS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .s_kind           (s_kind),
        .s_pwm_period     (s_pwm_period),
        .s_pwm_high_time  (s_pwm_high_time),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_throttle_level (m_throttle_level),
        .m_filtered_duty  (m_filtered_duty),
        .m_signal_present (m_signal_present),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

endmodule
